// ===== design/pc_pkg.sv =====
`timescale 1ns / 1ps
package pc_pkg;
    localparam int X_W         = 24;            // sample field width
    localparam int CNT_W       = 11;
    localparam int MAX_SAMPLES = 1024;
    localparam int SX_W        = 34;            // sum of samples
    localparam int SQ_W        = 58;            // sum of products
    localparam int PR_W        = 2 * X_W;       // one sample product
    localparam int MAG_W       = 68;            // magnitudes in the final math
    localparam int PROD_W      = 2 * MAG_W;
    localparam int COEF_W      = 16;
    localparam int STAT_W      = 2;

    localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
    localparam logic [STAT_W-1:0] ST_FEW  = 2'd1;
    localparam logic [STAT_W-1:0] ST_OVER = 2'd2;

    typedef struct packed {
        logic signed [X_W-1:0] x;
        logic signed [X_W-1:0] y;
        logic                  last;
    } t_pair;

    typedef struct packed {
        logic [CNT_W-1:0]       cnt;
        logic signed [SX_W-1:0] sx;
        logic signed [SX_W-1:0] sy;
        logic [SQ_W-1:0]        sxx;
        logic [SQ_W-1:0]        syy;
        logic signed [SQ_W-1:0] sxy;
        logic                   ovf;
    } t_sums;

    typedef struct packed {
        logic [COEF_W-1:0] coef;
        logic [STAT_W-1:0] status;
    } t_result;
endpackage

// ===== design/pc_front.sv =====
`timescale 1ns / 1ps
module pc_front import pc_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_tvalid,
    output logic             o_tready,
    input  logic [2*X_W-1:0] i_tdata,
    input  logic             i_tlast,
    output logic             o_pair_valid,
    output t_pair            o_pair,
    input  logic             i_pair_ready
);
    // 4-deep queue of received pairs
    t_pair      r_mem [4];
    logic [1:0] r_wp, r_rp;
    logic [2:0] r_cnt;
    logic       push, pop;

    assign o_tready     = (r_cnt != 3'd4);
    assign o_pair_valid = (r_cnt != 3'd0);
    assign o_pair       = r_mem[r_rp];
    assign push         = i_tvalid & o_tready;
    assign pop          = o_pair_valid & i_pair_ready;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= '{x: i_tdata[X_W-1:0], y: i_tdata[2*X_W-1:X_W], last: i_tlast};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) r_wp <= r_wp + 2'd1;
            if (pop)  r_rp <= r_rp + 2'd1;
            r_cnt <= r_cnt + {2'd0, push} - {2'd0, pop};
        end
    end
endmodule

// ===== design/pc_smul.sv =====
`timescale 1ns / 1ps
module pc_smul import pc_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [MAG_W-1:0]  i_a,
    input  logic [MAG_W-1:0]  i_b,
    output logic              o_done,
    output logic [PROD_W-1:0] o_p
);
    // shift-add, one multiplier bit per cycle
    logic [PROD_W-1:0] r_a, r_acc;
    logic [MAG_W-1:0]  r_b;
    logic [6:0]        r_cnt;
    logic              r_busy, r_done;

    assign o_done = r_done;
    assign o_p    = r_acc;

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a   <= PROD_W'(i_a);
            r_b   <= i_b;
            r_acc <= '0;
        end else if (r_busy) begin
            if (r_b[0]) r_acc <= r_acc + r_a;
            r_a <= r_a << 1;
            r_b <= r_b >> 1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 7'(MAG_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 7'd1;
                if (r_cnt == 7'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end
endmodule

// ===== design/pc_finish.sv =====
`timescale 1ns / 1ps
module pc_finish import pc_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_start,
    input  t_sums   i_sums,
    output logic    o_busy,
    output logic    o_done,
    output t_result o_res
);
    localparam logic [3:0] F_IDLE = 4'd0,  F_M1 = 4'd1,  F_M2 = 4'd2,  F_M3 = 4'd3,
                           F_M4   = 4'd4,  F_M5 = 4'd5,  F_M6 = 4'd6,  F_CHK = 4'd7,
                           F_M7   = 4'd8,  F_M8 = 4'd9,  F_DIV = 4'd10, F_SQRT = 4'd11,
                           F_OUT  = 4'd12, F_RND = 4'd13;

    function automatic logic [MAG_W-1:0] f_mag(input logic signed [MAG_W+1:0] v);
        return v[MAG_W+1] ? MAG_W'(-v) : MAG_W'(v);
    endfunction

    logic [3:0]        r_state;
    logic              r_go;
    t_sums             r_s;
    logic [MAG_W-1:0]  r_nsxy, r_sxsy, r_nsxx, r_sxsx, r_nsyy, r_sysy;
    logic [MAG_W-1:0]  r_vx, r_vy, r_nm;
    logic              r_neg;
    logic [PROD_W-1:0] r_p;
    logic [PROD_W:0]   r_rem;
    logic [32:0]       r_q;
    logic [5:0]        r_dcnt;
    logic [16:0]       r_sq;
    logic [4:0]        r_bit;
    t_result           r_res;

    logic [MAG_W-1:0]        mul_a, mul_b, mag_sx, mag_sy, mag_sxy, cnt_ext;
    logic                    mul_done;
    logic [PROD_W-1:0]       mul_p;
    logic signed [MAG_W+1:0] t1, t2, num, vx, vy;
    logic                    ge;
    logic [PROD_W:0]         rem_sub;
    logic [16:0]             trial, k;
    logic [33:0]             trial_sq;

    assign mag_sx  = f_mag((MAG_W+2)'(r_s.sx));
    assign mag_sy  = f_mag((MAG_W+2)'(r_s.sy));
    assign mag_sxy = f_mag((MAG_W+2)'(r_s.sxy));
    assign cnt_ext = MAG_W'(r_s.cnt);

    always_comb begin
        case (r_state)
            F_M1:    begin mul_a = cnt_ext; mul_b = mag_sxy;            end
            F_M2:    begin mul_a = mag_sx;  mul_b = mag_sy;             end
            F_M3:    begin mul_a = cnt_ext; mul_b = MAG_W'(r_s.sxx);    end
            F_M4:    begin mul_a = mag_sx;  mul_b = mag_sx;             end
            F_M5:    begin mul_a = cnt_ext; mul_b = MAG_W'(r_s.syy);    end
            F_M6:    begin mul_a = mag_sy;  mul_b = mag_sy;             end
            F_M7:    begin mul_a = r_vx;    mul_b = r_vy;               end
            F_M8:    begin mul_a = r_nm;    mul_b = r_nm;               end
            default: begin mul_a = '0;      mul_b = '0;                 end
        endcase
    end

    pc_smul u_smul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_go),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .o_done  (mul_done),
        .o_p     (mul_p)
    );

    // numerator sign follows the signs of sxy and sx*sy
    always_comb begin
        t1  = r_s.sxy[SQ_W-1] ? -$signed({2'b00, r_nsxy}) : $signed({2'b00, r_nsxy});
        t2  = (r_s.sx[SX_W-1] ^ r_s.sy[SX_W-1]) ? -$signed({2'b00, r_sxsy})
                                                 : $signed({2'b00, r_sxsy});
        num = t1 - t2;
        vx  = $signed({2'b00, r_nsxx}) - $signed({2'b00, r_sxsx});
        vy  = $signed({2'b00, r_nsyy}) - $signed({2'b00, r_sysy});
    end

    // restoring division step and square root trial
    assign ge       = (r_rem >= {1'b0, r_p});
    assign rem_sub  = ge ? (r_rem - {1'b0, r_p}) : r_rem;
    assign trial    = r_sq | (17'd1 << r_bit);
    assign trial_sq = trial * trial;
    assign k        = (r_sq + 17'd1) >> 1;

    assign o_busy = (r_state != F_IDLE);
    assign o_done = (r_state == F_OUT);
    assign o_res  = r_res;

    always_ff @(posedge i_clk) begin
        if (i_start) r_s <= i_sums;
        if (mul_done) begin
            case (r_state)
                F_M1:    r_nsxy <= mul_p[MAG_W-1:0];
                F_M2:    r_sxsy <= mul_p[MAG_W-1:0];
                F_M3:    r_nsxx <= mul_p[MAG_W-1:0];
                F_M4:    r_sxsx <= mul_p[MAG_W-1:0];
                F_M5:    r_nsyy <= mul_p[MAG_W-1:0];
                F_M6:    r_sysy <= mul_p[MAG_W-1:0];
                F_M7:    r_p    <= mul_p;
                default: ;
            endcase
        end
        if (r_state == F_CHK) begin
            r_vx  <= f_mag(vx);
            r_vy  <= f_mag(vy);
            r_nm  <= f_mag(num);
            r_neg <= num[MAG_W+1];
        end
        if (r_state == F_M8 && mul_done) begin
            r_rem <= {1'b0, mul_p};
            r_q   <= '0;
        end else if (r_state == F_DIV) begin
            r_q   <= {r_q[31:0], ge};
            r_rem <= rem_sub << 1;
        end
        if (r_state == F_DIV && r_dcnt == 6'd1) begin
            r_sq  <= '0;
        end else if (r_state == F_SQRT && trial_sq <= {1'b0, r_q}) begin
            r_sq <= trial;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
            r_go    <= 1'b0;
            r_dcnt  <= '0;
            r_bit   <= '0;
            r_res   <= '0;
        end else begin
            r_go <= 1'b0;
            case (r_state)
                F_IDLE: begin
                    if (i_start) begin
                        if (i_sums.ovf) begin
                            r_res   <= '{coef: '0, status: ST_OVER};
                            r_state <= F_OUT;
                        end else if (i_sums.cnt < CNT_W'(2)) begin
                            r_res   <= '{coef: '0, status: ST_FEW};
                            r_state <= F_OUT;
                        end else begin
                            r_state <= F_M1;
                            r_go    <= 1'b1;
                        end
                    end
                end
                F_M1, F_M2, F_M3, F_M4, F_M5: begin
                    if (mul_done) begin
                        r_state <= r_state + 4'd1;
                        r_go    <= 1'b1;
                    end
                end
                F_M6: begin
                    if (mul_done) r_state <= F_CHK;
                end
                F_CHK: begin
                    if (vx <= 0 || vy <= 0) begin
                        r_res   <= '{coef: '0, status: ST_FEW};
                        r_state <= F_OUT;
                    end else begin
                        r_state <= F_M7;
                        r_go    <= 1'b1;
                    end
                end
                F_M7: begin
                    if (mul_done) begin
                        r_state <= F_M8;
                        r_go    <= 1'b1;
                    end
                end
                F_M8: begin
                    if (mul_done) begin
                        r_state <= F_DIV;
                        r_dcnt  <= 6'd33;
                    end
                end
                F_DIV: begin
                    r_dcnt <= r_dcnt - 6'd1;
                    if (r_dcnt == 6'd1) begin
                        r_state <= F_SQRT;
                        r_bit   <= 5'd16;
                    end
                end
                F_SQRT: begin
                    r_bit <= r_bit - 5'd1;
                    if (r_bit == 5'd0) r_state <= F_RND;
                end
                F_RND: begin
                    // rounding: k = floor((isqrt + 1) / 2), sign applied last
                    if (r_neg) begin
                        r_res <= '{coef: COEF_W'(-k), status: ST_OK};
                    end else if (k > 17'd32767) begin
                        r_res <= '{coef: 16'h7FFF, status: ST_OK};
                    end else begin
                        r_res <= '{coef: k[COEF_W-1:0], status: ST_OK};
                    end
                    r_state <= F_OUT;
                end
                F_OUT: r_state <= F_IDLE;
                default: r_state <= F_IDLE;
            endcase
        end
    end
endmodule

// ===== design/pc_back.sv =====
`timescale 1ns / 1ps
module pc_back import pc_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_pair_valid,
    input  t_pair               i_pair,
    output logic                o_pair_ready,
    output logic                o_tvalid,
    input  logic                i_tready,
    output logic [COEF_W-1:0]   o_tdata,
    output logic [STAT_W-1:0]   o_tuser
);
    localparam logic [1:0] B_IDLE = 2'd0, B_MUL = 2'd1, B_ADD = 2'd2;

    logic [1:0]             r_state;
    logic signed [X_W-1:0]  r_x, r_y;
    logic                   r_last;
    logic signed [PR_W-1:0] r_pxx, r_pyy, r_pxy;
    t_sums                  r_acc;
    logic                   r_out_valid;
    t_result                r_out;

    t_sums   n_acc;
    logic    can_go, fin_start, fin_busy, fin_done;
    t_result fin_res;

    assign o_pair_ready = (r_state == B_IDLE);
    assign can_go       = !r_last || (!fin_busy && !r_out_valid);
    assign fin_start    = (r_state == B_ADD) && r_last && can_go;

    always_comb begin
        n_acc = r_acc;
        if (r_acc.cnt < CNT_W'(MAX_SAMPLES)) begin
            n_acc.cnt = r_acc.cnt + CNT_W'(1);
            n_acc.sx  = r_acc.sx + SX_W'(r_x);
            n_acc.sy  = r_acc.sy + SX_W'(r_y);
            n_acc.sxx = r_acc.sxx + SQ_W'($unsigned(r_pxx));
            n_acc.syy = r_acc.syy + SQ_W'($unsigned(r_pyy));
            n_acc.sxy = r_acc.sxy + SQ_W'(r_pxy);
        end else begin
            n_acc.ovf = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == B_IDLE && i_pair_valid) begin
            r_x <= i_pair.x;
            r_y <= i_pair.y;
        end
        if (r_state == B_MUL) begin
            r_pxx <= r_x * r_x;
            r_pyy <= r_y * r_y;
            r_pxy <= r_x * r_y;
        end
        if (fin_done) r_out <= fin_res;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_IDLE;
            r_last      <= 1'b0;
            r_acc       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            case (r_state)
                B_IDLE: begin
                    if (i_pair_valid) begin
                        r_last  <= i_pair.last;
                        r_state <= B_MUL;
                    end
                end
                B_MUL: r_state <= B_ADD;
                B_ADD: begin
                    if (can_go) begin
                        r_acc   <= r_last ? '0 : n_acc;
                        r_state <= B_IDLE;
                    end
                end
                default: r_state <= B_IDLE;
            endcase
            if (fin_done)                  r_out_valid <= 1'b1;
            else if (r_out_valid && i_tready) r_out_valid <= 1'b0;
        end
    end

    pc_finish u_finish (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (fin_start),
        .i_sums  (n_acc),
        .o_busy  (fin_busy),
        .o_done  (fin_done),
        .o_res   (fin_res)
    );

    assign o_tvalid = r_out_valid;
    assign o_tdata  = r_out.coef;
    assign o_tuser  = r_out.status;
endmodule

// ===== design/pearson_correlation.sv =====
`timescale 1ns / 1ps
// channel   | direction | payload
// ----------+-----------+-----------------------------------------------
// s_axis    | in        | tdata {y_sample, x_sample}, tlast = last_pair
// m_axis    | out       | tdata coefficient (Q1.15), tuser status
//
// Each pair passes the accumulator steps pop, multiply and add; a
// 4-entry queue in front takes pairs at one per cycle until it fills.
// A series result follows its last pair through eight shift-add
// multiplies of 68 bit steps each, a 33-bit restoring division, an
// integer square root of 17 bits and a rounding step.
// The next series accumulates meanwhile; its last pair waits until the
// previous result has left the output register.
// Reset is synchronous, active low, and clears count, sums and control.
module pearson_correlation import pc_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_axis_tvalid,
    output logic              o_s_axis_tready,
    input  logic [2*X_W-1:0]  i_s_axis_tdata,   // [23:0] x_sample, [47:24] y_sample
    input  logic              i_s_axis_tlast,
    output logic              o_m_axis_tvalid,
    input  logic              i_m_axis_tready,
    output logic [COEF_W-1:0] o_m_axis_tdata,   // [15:0] coefficient
    output logic [STAT_W-1:0] o_m_axis_tuser    // [1:0] status
);
    logic  pair_valid, pair_ready;
    t_pair pair;

    // front: take transactions and queue them
    pc_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_tvalid     (i_s_axis_tvalid),
        .o_tready     (o_s_axis_tready),
        .i_tdata      (i_s_axis_tdata),
        .i_tlast      (i_s_axis_tlast),
        .o_pair_valid (pair_valid),
        .o_pair       (pair),
        .i_pair_ready (pair_ready)
    );

    // back: accumulate, finish, hold result
    pc_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_pair_valid (pair_valid),
        .i_pair       (pair),
        .o_pair_ready (pair_ready),
        .o_tvalid     (o_m_axis_tvalid),
        .i_tready     (i_m_axis_tready),
        .o_tdata      (o_m_axis_tdata),
        .o_tuser      (o_m_axis_tuser)
    );
endmodule
